// File: design/mlss_pkg.sv
// ----------------------------------------------------------------------------
// mlss_pkg
// Types and constants shared by the Morse LED segment sequencer modules.
// ----------------------------------------------------------------------------
package mlss_pkg;

  localparam int unsigned DUR_W   = 16;
  localparam int unsigned UNIT_W  = 12;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned NSEG_W  = 3;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // Register word index, taken from paddr[2]
  localparam logic REG_START_LOW = 1'b0;
  localparam logic REG_UNIT_MS   = 1'b1;

  localparam logic [UNIT_W-1:0] UNIT_MS_RESET = 12'd100;

  // Characters of the Morse element and text commands
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [SYM_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [SYM_W-1:0] CH_LT    = 8'h3C;
  localparam logic [SYM_W-1:0] CH_GT    = 8'h3E;
  localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;

  // Canned pattern timings
  localparam logic [DUR_W-1:0] RECV_MS      = 16'd100;
  localparam logic [DUR_W-1:0] ERR_MS       = 16'd80;
  localparam logic [DUR_W-1:0] SENT_ON_MS   = 16'd200;
  localparam logic [DUR_W-1:0] SENT_OFF_MS  = 16'd100;
  localparam logic [NSEG_W-1:0] NSEG_RAW    = 3'd1;
  localparam logic [NSEG_W-1:0] NSEG_ELEM   = 3'd2;
  localparam logic [NSEG_W-1:0] NSEG_RECV   = 3'd4;
  localparam logic [NSEG_W-1:0] NSEG_ERR    = 3'd6;
  localparam logic [NSEG_W-1:0] NSEG_SENT   = 3'd4;

  typedef enum logic [2:0] {
    OP_TIME  = 3'd0,
    OP_RAW   = 3'd1,
    OP_ELEM  = 3'd2,
    OP_TEXT  = 3'd3,
    OP_RECV  = 3'd4,
    OP_ERR   = 3'd5,
    OP_SENT  = 3'd6,
    OP_STOP  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    JOB_TICK = 2'd0,
    JOB_PUSH = 2'd1,
    JOB_STOP = 2'd2
  } job_kind_e;

  typedef struct packed {
    op_e              opcode;
    logic             level_on;
    logic [DUR_W-1:0] duration_ms;
    logic [SYM_W-1:0] symbol;
    logic [DUR_W-1:0] elapsed_ms;
  } cmd_t;

  typedef struct packed {
    logic               led_level;
    logic [COUNT_W-1:0] queue_count;
    logic               overflow;
  } res_t;

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] dur;
  } seg_t;

  // Even segments come from seg_a, odd ones from seg_b; a tick carries the
  // elapsed time in seg_a.dur.
  typedef struct packed {
    job_kind_e         kind;
    logic [NSEG_W-1:0] nseg;
    seg_t              seg_a;
    seg_t              seg_b;
  } job_t;

  typedef struct packed {
    logic              start_low;
    logic [UNIT_W-1:0] unit_ms;
  } cfg_t;

endpackage

// File: design/mlss_ram.sv
// ----------------------------------------------------------------------------
// mlss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlss_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mlss_fifo.sv
// ----------------------------------------------------------------------------
// mlss_fifo
// Small register FIFO with first-word-fall-through read.
// ----------------------------------------------------------------------------
module mlss_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = data_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: design/mlss_front.sv
// ----------------------------------------------------------------------------
// mlss_front
// Configuration registers and command decode: turns each item into a job
// (tick, stop, or a list of up to six segments) for the back end.
// ----------------------------------------------------------------------------
module mlss_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [mlss_pkg::APB_AW-1:0]  paddr_i,
  input  logic [mlss_pkg::APB_DW-1:0]  pwdata_i,
  output logic [mlss_pkg::APB_DW-1:0]  prdata_o,
  input  logic                         push_i,
  input  mlss_pkg::cmd_t               cmd_i,
  input  logic                         job_full_i,
  output logic                         job_push_o,
  output mlss_pkg::job_t               job_o,
  output mlss_pkg::cfg_t               cfg_o
);

  logic                            start_low_q;
  logic [mlss_pkg::UNIT_W-1:0]     unit_ms_q;
  logic                            cfg_wr;
  logic [mlss_pkg::DUR_W-1:0]      unit1, unit3, unit7;
  logic                            lvl_on, lvl_off;

  assign cfg_wr = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q <= 1'b0;
      unit_ms_q   <= mlss_pkg::UNIT_MS_RESET;
    end else if (cfg_wr) begin
      if (paddr_i[2] == mlss_pkg::REG_START_LOW) begin
        start_low_q <= pwdata_i[0];
      end else begin
        unit_ms_q <= pwdata_i[mlss_pkg::UNIT_W-1:0];
      end
    end
  end

  always_comb begin
    prdata_o = '0;
    if (paddr_i[2] == mlss_pkg::REG_START_LOW) begin
      prdata_o[0] = start_low_q;
    end else begin
      prdata_o[mlss_pkg::UNIT_W-1:0] = unit_ms_q;
    end
  end

  assign cfg_o.start_low = start_low_q;
  assign cfg_o.unit_ms   = unit_ms_q;

  // Multiples of the unit never exceed 16 bits for a 12-bit unit
  assign unit1 = mlss_pkg::DUR_W'(unit_ms_q);
  assign unit3 = (unit1 << 1) + unit1;
  assign unit7 = (unit1 << 3) - unit1;

  // Polarity is applied as the segment is queued
  assign lvl_on  = start_low_q;
  assign lvl_off = !start_low_q;

  assign job_push_o = push_i && !job_full_i;

  always_comb begin
    job_o       = '0;
    job_o.kind  = mlss_pkg::JOB_PUSH;
    unique case (cmd_i.opcode)
      mlss_pkg::OP_TIME: begin
        job_o.kind      = mlss_pkg::JOB_TICK;
        job_o.seg_a.dur = cmd_i.elapsed_ms;
      end
      mlss_pkg::OP_RAW: begin
        job_o.nseg  = mlss_pkg::NSEG_RAW;
        job_o.seg_a = '{level: cmd_i.level_on ^ !start_low_q, dur: cmd_i.duration_ms};
      end
      mlss_pkg::OP_ELEM: begin
        if (cmd_i.symbol != mlss_pkg::CH_SPACE) begin
          job_o.nseg  = mlss_pkg::NSEG_ELEM;
          job_o.seg_a = '{level: lvl_on,
                          dur: (cmd_i.symbol == mlss_pkg::CH_DOT) ? unit1 : unit3};
          job_o.seg_b = '{level: lvl_off, dur: unit1};
        end
      end
      mlss_pkg::OP_TEXT: begin
        job_o.nseg = mlss_pkg::NSEG_RAW;
        case (cmd_i.symbol)
          mlss_pkg::CH_DOT:   job_o.seg_a = '{level: lvl_on,  dur: unit1};
          mlss_pkg::CH_DASH:  job_o.seg_a = '{level: lvl_on,  dur: unit3};
          mlss_pkg::CH_LT:    job_o.seg_a = '{level: lvl_off, dur: unit3};
          mlss_pkg::CH_CARET: job_o.seg_a = '{level: lvl_off, dur: unit1};
          mlss_pkg::CH_GT:    job_o.seg_a = '{level: lvl_off, dur: unit7};
          default:            job_o.nseg  = '0;
        endcase
      end
      mlss_pkg::OP_RECV: begin
        job_o.nseg  = mlss_pkg::NSEG_RECV;
        job_o.seg_a = '{level: lvl_on,  dur: mlss_pkg::RECV_MS};
        job_o.seg_b = '{level: lvl_off, dur: mlss_pkg::RECV_MS};
      end
      mlss_pkg::OP_ERR: begin
        job_o.nseg  = mlss_pkg::NSEG_ERR;
        job_o.seg_a = '{level: lvl_on,  dur: mlss_pkg::ERR_MS};
        job_o.seg_b = '{level: lvl_off, dur: mlss_pkg::ERR_MS};
      end
      mlss_pkg::OP_SENT: begin
        job_o.nseg  = mlss_pkg::NSEG_SENT;
        job_o.seg_a = '{level: lvl_on,  dur: mlss_pkg::SENT_ON_MS};
        job_o.seg_b = '{level: lvl_off, dur: mlss_pkg::SENT_OFF_MS};
      end
      mlss_pkg::OP_STOP: begin
        job_o.kind = mlss_pkg::JOB_STOP;
      end
      default: begin
        job_o.kind = mlss_pkg::JOB_STOP;
      end
    endcase
  end

endmodule

// File: design/mlss_back.sv
// ----------------------------------------------------------------------------
// mlss_back
// Executes jobs against the segment queue and the LED timing state, and
// hands one result per job to the result queue.
// ----------------------------------------------------------------------------
module mlss_back #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned NEAR_END_MS = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mlss_pkg::cfg_t cfg_i,
  input  logic           job_valid_i,
  input  mlss_pkg::job_t job_i,
  output logic           job_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output mlss_pkg::res_t res_o
);

  localparam int unsigned AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SEG_W = $bits(mlss_pkg::seg_t);
  localparam logic signed [mlss_pkg::DUR_W:0] NearEnd = (mlss_pkg::DUR_W + 1)'(NEAR_END_MS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_READ,
    ST_RESP
  } state_e;

  state_e                          state_q, state_d;
  mlss_pkg::job_t                  job_q, job_d;
  logic [mlss_pkg::NSEG_W-1:0]     idx_q, idx_d;
  logic [AW-1:0]                   head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]                   fill_q, fill_d;
  logic [mlss_pkg::DUR_W-1:0]      rem_q, rem_d;
  logic                            level_q, level_d;
  logic                            dropped_q, dropped_d;

  logic                            ram_we, ram_re;
  logic [SEG_W-1:0]                ram_wdata;
  mlss_pkg::seg_t                  ram_rdata;
  logic signed [mlss_pkg::DUR_W:0] diff;

  mlss_ram #(
    .WIDTH(SEG_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_seg_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  assign diff = $signed({1'b0, rem_q}) - $signed({1'b0, job_i.seg_a.dur});

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    idx_d      = idx_q;
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    rem_d      = rem_q;
    level_d    = level_q;
    dropped_d  = dropped_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_wdata  = (idx_q[0]) ? job_q.seg_b : job_q.seg_a;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          idx_d     = '0;
          dropped_d = 1'b0;
          state_d   = ST_RESP;
          case (job_i.kind)
            mlss_pkg::JOB_PUSH: begin
              state_d = ST_PUSH;
            end
            mlss_pkg::JOB_TICK: begin
              if (diff < NearEnd) begin
                if (fill_q != '0) begin
                  // Fetch the head segment; it lands next cycle
                  ram_re  = 1'b1;
                  state_d = ST_READ;
                end else begin
                  level_d = cfg_i.start_low;
                  head_d  = '0;
                  tail_d  = '0;
                  fill_d  = '0;
                  rem_d   = diff[mlss_pkg::DUR_W] ? '0 : diff[mlss_pkg::DUR_W-1:0];
                end
              end else begin
                rem_d = diff[mlss_pkg::DUR_W-1:0];
              end
            end
            default: begin
              level_d = cfg_i.start_low;
              head_d  = '0;
              tail_d  = '0;
              fill_d  = '0;
            end
          endcase
        end
      end
      ST_PUSH: begin
        if (idx_q == job_q.nseg) begin
          state_d = ST_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
          if (fill_q == CW'(QUEUE_DEPTH)) begin
            dropped_d = 1'b1;
          end else begin
            ram_we = 1'b1;
            tail_d = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
            fill_d = fill_q + 1'b1;
          end
        end
      end
      ST_READ: begin
        level_d = ram_rdata.level;
        rem_d   = ram_rdata.dur;
        head_d  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
        fill_d  = fill_q - 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.led_level   = level_q;
  assign res_o.queue_count = mlss_pkg::COUNT_W'(fill_q);
  assign res_o.overflow    = dropped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
      rem_q     <= '0;
      level_q   <= 1'b0;
      dropped_q <= 1'b0;
      idx_q     <= '0;
      job_q     <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      fill_q    <= fill_d;
      rem_q     <= rem_d;
      level_q   <= level_d;
      dropped_q <= dropped_d;
      idx_q     <= idx_d;
      job_q     <= job_d;
    end
  end

endmodule

// File: design/morse_led_segment_sequencer_top.sv
// The back end takes one job at a time from the job queue in its idle state; a tick
// that loads the next segment then passes the read state, and a command item the
// push state, which writes one segment a cycle into the segment RAM. Each job ends in
// the response state, which waits while the result queue is full.
// Reset clears the pointers, fill count, timing state and both small queues at
// once; the segment RAM is not cleared, since only written entries are read.
// ----------------------------------------------------------------------------
// morse_led_segment_sequencer_top
// LED segment sequencer: command decode front end, job queue, segment
// execution back end and result queue.
// ----------------------------------------------------------------------------
module morse_led_segment_sequencer_top #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned NEAR_END_MS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  mlss_pkg::cmd_t              cmd_i,
  output logic                        empty,
  input  logic                        pop,
  output mlss_pkg::res_t              res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mlss_pkg::APB_AW-1:0] paddr,
  input  logic [mlss_pkg::APB_DW-1:0] pwdata,
  output logic [mlss_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned JobQDepth = 2;
  localparam int unsigned ResQDepth = 2;

  mlss_pkg::cfg_t cfg;
  mlss_pkg::job_t job_in, job_out;
  mlss_pkg::res_t res_in;
  logic           job_push, job_empty, job_pop;
  logic           res_push, res_full;

  assign pready = 1'b1;

  mlss_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .push_i    (push),
    .cmd_i     (cmd_i),
    .job_full_i(full),
    .job_push_o(job_push),
    .job_o     (job_in),
    .cfg_o     (cfg)
  );

  mlss_fifo #(
    .WIDTH($bits(mlss_pkg::job_t)),
    .DEPTH(JobQDepth)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_in),
    .full_o (full),
    .pop_i  (job_pop),
    .rdata_o(job_out),
    .empty_o(job_empty)
  );

  mlss_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .NEAR_END_MS(NEAR_END_MS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .job_valid_i(!job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  mlss_fifo #(
    .WIDTH($bits(mlss_pkg::res_t)),
    .DEPTH(ResQDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_o),
    .empty_o(empty)
  );

endmodule

// File: design/mlss_checker.sv
// ----------------------------------------------------------------------------
// mlss_checker
// Port-level checks for the LED segment sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module mlss_checker #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        empty,
  input logic                        pop,
  input mlss_pkg::res_t              res_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [mlss_pkg::APB_AW-1:0] paddr,
  input logic [mlss_pkg::APB_DW-1:0] pwdata,
  input logic [mlss_pkg::APB_DW-1:0] prdata
);

  // No result is shown once reset has been seen at a clock edge
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result shown during reset");

  // A waiting result holds until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(res_o))
    else $error("waiting result changed");

  // Dropping a segment means the queue ended the item full
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && res_o.overflow |-> res_o.queue_count == mlss_pkg::COUNT_W'(QUEUE_DEPTH))
    else $error("overflow with room left in queue");

  // A polarity write reads back on the next cycle
  a_polarity_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[2] == mlss_pkg::REG_START_LOW
    |=> paddr[2] != mlss_pkg::REG_START_LOW || prdata[0] == $past(pwdata[0]))
    else $error("polarity register readback mismatch");

endmodule

bind morse_led_segment_sequencer_top mlss_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_mlss_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty  (empty),
  .pop    (pop),
  .res_o  (res_o),
  .psel   (psel),
  .penable(penable),
  .pwrite (pwrite),
  .paddr  (paddr),
  .pwdata (pwdata),
  .prdata (prdata)
);
